/* src/bmvg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmvg_pkg: shared types and codes for the base mode and velocity gate
// Item layouts, item kinds, mode command codes and control states.
// ----------------------------------------------------------------------------
package bmvg_pkg;

    localparam int unsigned VEL_W  = 32;
    localparam int unsigned TIME_W = 63;
    localparam int unsigned TMO_W  = 32;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd1000000;

    // item kinds
    localparam logic [1:0] KIND_MODE   = 2'd0;
    localparam logic [1:0] KIND_VEL    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // mode command codes
    localparam logic [2:0] MODE_DISABLE = 3'd1;
    localparam logic [2:0] MODE_ENABLE  = 3'd2;
    localparam logic [2:0] MODE_ESTOP   = 3'd3;
    localparam logic [2:0] MODE_STOP    = 3'd4;
    localparam logic [2:0] MODE_FREEZE  = 3'd5;
    localparam logic [2:0] MODE_START   = 3'd6;

    typedef enum logic [2:0] {
        CS_UNKNOWN = 3'd0,
        CS_DISABLE = 3'd1,
        CS_ENABLE  = 3'd2,
        CS_ESTOP   = 3'd3,
        CS_STANDBY = 3'd4,
        CS_READY   = 3'd5,
        CS_RUNNING = 3'd6
    } t_ctrl_state;

    typedef struct packed {
        logic [1:0]              kind;
        logic [2:0]              mode_cmd;
        logic                    link_active;
        logic signed [VEL_W-1:0] in_vel_x;
        logic signed [VEL_W-1:0] in_vel_y;
        logic signed [VEL_W-1:0] in_vel_yaw;
        logic [TIME_W-1:0]       status_time;
        logic                    calibrated;
        logic                    time_synced;
    } t_in_item;

    typedef struct packed {
        logic                    refused;
        logic [2:0]              reported_state;
        logic                    forwarding;
        logic                    halted;
        logic signed [VEL_W-1:0] out_vel_x;
        logic signed [VEL_W-1:0] out_vel_y;
        logic signed [VEL_W-1:0] out_vel_yaw;
        logic [TIME_W-1:0]       heartbeat_time;
    } t_out_item;

endpackage

/* src/bmvg_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmvg_stream_if: valid/ready channel
// Carries one payload per transfer; source drives valid and data.
// ----------------------------------------------------------------------------
interface bmvg_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/bmvg_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmvg_in_stage: input register
// Captures one item per transfer and holds it until the core takes it.
// ----------------------------------------------------------------------------
module bmvg_in_stage
    import bmvg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    bmvg_stream_if.sink         i_in,
    input  logic                i_adv,
    output logic                o_vld,
    output t_in_item            o_item
);

    logic     r_vld;
    t_in_item r_item;
    logic     w_load;

    // free slot, or the held item leaves this cycle
    assign i_in.ready = !r_vld || i_adv;
    assign w_load     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_in.data;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

/* src/bmvg_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmvg_core: mode machine, velocity latch, status handling, result register
// Updates gate state from the registered item when the output can advance.
// ----------------------------------------------------------------------------
module bmvg_core
    import bmvg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [TMO_W-1:0]    i_cfg_wdata,
    input  logic                i_vld,
    input  t_in_item            i_item,
    output logic                o_adv,
    bmvg_stream_if.source       o_out
);

    logic [TMO_W-1:0]        r_timeout;
    t_ctrl_state             r_ctrl,  n_ctrl;
    logic                    r_en,    n_en;
    logic                    r_fwd,   n_fwd;
    logic                    r_halt,  n_halt;
    logic signed [VEL_W-1:0] r_vel_x, n_vel_x;
    logic signed [VEL_W-1:0] r_vel_y, n_vel_y;
    logic signed [VEL_W-1:0] r_vel_yaw, n_vel_yaw;
    logic [TIME_W-1:0]       r_last_stat, n_last_stat;
    logic [TIME_W-1:0]       r_last_cmd,  n_last_cmd;
    logic [TIME_W-1:0]       r_echo,      n_echo;
    logic                    r_out_vld;
    t_out_item               r_out, n_out;
    logic [TIME_W:0]         w_diff;
    logic                    w_expired;
    logic                    w_refused;
    logic                    w_step;

    assign o_adv  = !r_out_vld || o_out.ready;
    assign w_step = i_vld && o_adv;

    // signed age of the last command; negative when time went backwards
    assign w_diff    = {1'b0, i_item.status_time} - {1'b0, r_last_cmd};
    assign w_expired = !w_diff[TIME_W] &&
                       (w_diff[TIME_W-1:0] > {{(TIME_W-TMO_W){1'b0}}, r_timeout});

    // next state
    always_comb begin
        n_ctrl      = r_ctrl;
        n_en        = r_en;
        n_fwd       = r_fwd;
        n_halt      = r_halt;
        n_vel_x     = r_vel_x;
        n_vel_y     = r_vel_y;
        n_vel_yaw   = r_vel_yaw;
        n_last_stat = r_last_stat;
        n_last_cmd  = r_last_cmd;
        n_echo      = r_echo;
        case (i_item.kind)
            KIND_MODE: begin
                if (i_item.link_active && !r_halt) begin
                    unique case (i_item.mode_cmd)
                        MODE_DISABLE: begin
                            n_en = 1'b0;
                            if (r_ctrl == CS_RUNNING) n_fwd = 1'b0;
                            if (r_ctrl != CS_ESTOP) n_ctrl = CS_STANDBY;
                        end
                        MODE_ENABLE: begin
                            n_en = 1'b1;
                        end
                        MODE_ESTOP: begin
                            if (r_en && r_ctrl == CS_RUNNING) n_fwd = 1'b0;
                            n_ctrl = CS_ESTOP;
                        end
                        MODE_STOP: begin
                            if (r_ctrl == CS_RUNNING) n_fwd = 1'b0;
                            n_ctrl = CS_STANDBY;
                        end
                        MODE_FREEZE: begin
                            if (r_en && r_ctrl != CS_ESTOP) begin
                                n_fwd  = 1'b0;
                                n_ctrl = CS_STANDBY;
                            end
                        end
                        MODE_START: begin
                            if (r_en && r_ctrl != CS_RUNNING && r_ctrl != CS_ESTOP) begin
                                n_fwd  = 1'b1;
                                n_ctrl = CS_RUNNING;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            KIND_VEL: begin
                if (r_fwd) begin
                    n_vel_x    = i_item.in_vel_x;
                    n_vel_y    = i_item.in_vel_y;
                    n_vel_yaw  = i_item.in_vel_yaw;
                    n_last_cmd = r_last_stat;
                end
            end
            KIND_STATUS: begin
                if (!r_halt) begin
                    n_last_stat = i_item.status_time;
                    if (!i_item.calibrated) begin
                        n_halt = 1'b1;
                        n_fwd  = 1'b0;
                    end else begin
                        if (r_fwd) n_echo = i_item.status_time;
                        if (i_item.time_synced && w_expired) begin
                            n_vel_x   = '0;
                            n_vel_y   = '0;
                            n_vel_yaw = '0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        w_refused = 1'b0;
        if (i_item.kind == KIND_MODE) begin
            if (!i_item.link_active || r_halt) begin
                w_refused = 1'b1;
            end else if ((i_item.mode_cmd == MODE_FREEZE || i_item.mode_cmd == MODE_START)
                         && r_en && r_ctrl == CS_ESTOP) begin
                w_refused = 1'b1;
            end
        end
        n_out.refused        = w_refused;
        n_out.reported_state = n_en ? n_ctrl : CS_DISABLE;
        n_out.forwarding     = n_fwd;
        n_out.halted         = n_halt;
        n_out.out_vel_x      = n_vel_x;
        n_out.out_vel_y      = n_vel_y;
        n_out.out_vel_yaw    = n_vel_yaw;
        n_out.heartbeat_time = n_echo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_ctrl      <= CS_DISABLE;
            r_en        <= 1'b0;
            r_fwd       <= 1'b0;
            r_halt      <= 1'b0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_vel_yaw   <= '0;
            r_last_stat <= '0;
            r_last_cmd  <= '0;
            r_echo      <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (w_step) begin
                r_ctrl      <= n_ctrl;
                r_en        <= n_en;
                r_fwd       <= n_fwd;
                r_halt      <= n_halt;
                r_vel_x     <= n_vel_x;
                r_vel_y     <= n_vel_y;
                r_vel_yaw   <= n_vel_yaw;
                r_last_stat <= n_last_stat;
                r_last_cmd  <= n_last_cmd;
                r_echo      <= n_echo;
            end
            if (o_adv) begin
                r_out_vld <= i_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // only reset clears a halt
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt cleared without reset");

    a_no_fwd_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> !r_fwd)
        else $error("forwarding while halted");

    a_refuse_mode_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && i_item.kind != KIND_MODE) |=> !r_out.refused)
        else $error("refusal on a non-mode item");

    a_vel_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> ($stable(r_vel_x) && $stable(r_vel_y) && $stable(r_vel_yaw)))
        else $error("velocity changed without an item");

endmodule

/* src/base_mode_and_velocity_gate_unit.sv */
`timescale 1ns / 1ps
// Pipeline: each input item passes through the input register and then the
//   result register, from which its result is offered on o_out.
// Throughput: one item per cycle; the input register reloads whenever it is
//   empty or the result register is empty or being drained.
// Reset: synchronous, active low; clears mode state, velocities, timestamps
//   and the timeout register to 1000000 us.
// ----------------------------------------------------------------------------
// base_mode_and_velocity_gate_unit: mobile-base command gate
// Mode machine, velocity latch with timeout and heartbeat echo.
// ----------------------------------------------------------------------------
module base_mode_and_velocity_gate_unit
    import bmvg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TMO_W-1:0] i_cfg_wdata,
    bmvg_stream_if.sink      i_in,
    bmvg_stream_if.source    o_out
);

    logic     w_adv;
    logic     w_vld;
    t_in_item w_item;

    bmvg_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (w_adv),
        .o_vld   (w_vld),
        .o_item  (w_item)
    );

    bmvg_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_vld       (w_vld),
        .i_item      (w_item),
        .o_adv       (w_adv),
        .o_out       (o_out)
    );

endmodule
